// ===== design/sds_pkg.sv =====
package sds_pkg;

  localparam int unsigned MaxSprites = 32;
  localparam int unsigned CoordBits  = 20;
  localparam int unsigned TagBits    = 8;
  localparam int unsigned SqBits     = 2 * CoordBits;
  localparam int unsigned DistBits   = 2 * CoordBits + 1;
  localparam int unsigned CntBits    = $clog2(MaxSprites + 1);
  localparam int unsigned CfgIdxBits = 1;

  // configuration register indexes
  typedef enum logic [CfgIdxBits-1:0] {
    CfgPlayerX = 1'b0,
    CfgPlayerY = 1'b1
  } cfg_reg_e;

  // one sorted list entry
  typedef struct packed {
    logic [DistBits-1:0]  dist_sq;
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
    logic [TagBits-1:0]   tag;
  } entry_t;

  typedef enum logic [1:0] {
    OpHold,
    OpInsert,
    OpShift
  } cell_op_e;

  typedef enum logic {
    StFill,
    StDrain
  } state_e;

  // status of the distance pipeline toward the list control
  typedef struct packed {
    logic valid;
    logic final_sprite;
    logic final_pending;
  } dist_stat_t;

endpackage

// ===== design/sds_in_if.sv =====
interface sds_in_if import sds_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CoordBits-1:0] sprite_x;
  logic [CoordBits-1:0] sprite_y;
  logic [TagBits-1:0]   sprite_tag;
  logic                 final_sprite;

  modport source (output valid, output sprite_x, output sprite_y, output sprite_tag,
                  output final_sprite, input ready);
  modport sink   (input valid, input sprite_x, input sprite_y, input sprite_tag,
                  input final_sprite, output ready);
endinterface

// ===== design/sds_out_if.sv =====
interface sds_out_if import sds_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [TagBits-1:0]   out_tag;
  logic [CoordBits-1:0] out_x;
  logic [CoordBits-1:0] out_y;
  logic                 out_last;
  logic                 dropped;

  modport source (output valid, output out_tag, output out_x, output out_y,
                  output out_last, output dropped, input ready);
  modport sink   (input valid, input out_tag, input out_x, input out_y,
                  input out_last, input dropped, output ready);
endinterface

// ===== design/sprite_depth_sort.sv =====
// Painter's-order depth sort. Sprites of one frame enter on in_i, one transaction each; the
// squared distance to the player (player_x/player_y, configuration indexes 0 and 1) is formed
// exactly in a two-stage pipeline (difference, then square) and the sprite is inserted into a
// row of MaxSprites compare-and-shift cells, so a frame streams in at one sprite
// per cycle. Sprites at equal distance keep arrival order. A sprite that finds the row full is
// discarded and every result of that frame carries dropped. The transaction marked
// final_sprite closes the frame: after it is accepted, in_i holds ready low while it passes
// the pipeline and while the row shifts out, farthest first, through an output register
// that follows out_o.ready; out_last marks the nearest sprite.
// The row then starts empty for the next frame. Player position applies to sprites accepted
// after the write; write it only while the block is idle.
module sprite_depth_sort import sds_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [CoordBits-1:0]  cfg_data_i,
  sds_in_if.sink                in_i,
  sds_out_if.source             out_o
);

  // configuration
  logic [CoordBits-1:0] player_x_q, player_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      player_x_q <= '0;
      player_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CfgPlayerX: player_x_q <= cfg_data_i;
        CfgPlayerY: player_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // distance pipeline
  logic       in_fire;
  logic       in_ready;
  dist_stat_t dstat;
  entry_t     new_entry;

  assign in_fire  = in_i.valid & in_ready;
  assign in_i.ready = in_ready;

  sds_dist u_dist (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_fire_i      (in_fire),
    .player_x_i     (player_x_q),
    .player_y_i     (player_y_q),
    .sprite_x_i     (in_i.sprite_x),
    .sprite_y_i     (in_i.sprite_y),
    .sprite_tag_i   (in_i.sprite_tag),
    .final_sprite_i (in_i.final_sprite),
    .stat_o         (dstat),
    .entry_o        (new_entry)
  );

  // list control
  state_e             state_q, state_d;
  logic [CntBits-1:0] count_q, count_d;
  logic               ovf_q, ovf_d;
  logic               full;
  logic               ins;
  logic               pop;
  cell_op_e           cell_op;

  logic   out_vld_q, out_vld_d;
  entry_t out_q;
  logic   out_last_q, out_drop_q;

  assign full = (count_q == CntBits'(MaxSprites));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StFill: begin
        if (dstat.valid && dstat.final_sprite) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (pop && count_q == CntBits'(1)) begin
          state_d = StFill;
        end
      end
      default: state_d = StFill;
    endcase
  end

  // outputs of the controller
  always_comb begin
    ins      = 1'b0;
    pop      = 1'b0;
    in_ready = 1'b0;
    case (state_q)
      StFill: begin
        ins      = dstat.valid;
        // hold off the next frame while its closing sprite is still in flight
        in_ready = !dstat.final_pending;
      end
      StDrain: begin
        pop = !out_vld_q || out_o.ready;
      end
      default: ;
    endcase
    if (ins && !full) begin
      cell_op = OpInsert;
    end else if (pop) begin
      cell_op = OpShift;
    end else begin
      cell_op = OpHold;
    end
  end

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (ins) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + CntBits'(1);
      end
    end else if (pop) begin
      count_d = count_q - CntBits'(1);
      if (count_q == CntBits'(1)) begin
        ovf_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StFill;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  // row of cells, cell 0 holds the farthest sprite
  entry_t cell_entry [MaxSprites];
  logic   cell_ge    [MaxSprites];

  for (genvar i = 0; i < MaxSprites; i++) begin : g_cell
    entry_t prev_entry, next_entry;
    logic   ge_prev;

    if (i == 0) begin : g_head
      assign prev_entry = new_entry;
      assign ge_prev    = 1'b1;
    end else begin : g_body
      assign prev_entry = cell_entry[i-1];
      assign ge_prev    = cell_ge[i-1];
    end

    if (i == MaxSprites - 1) begin : g_tail
      assign next_entry = cell_entry[i];
    end else begin : g_inner
      assign next_entry = cell_entry[i+1];
    end

    sds_cell u_cell (
      .clk_i      (clk_i),
      .op_i       (cell_op),
      .occupied_i (count_q > CntBits'(i)),
      .ge_prev_i  (ge_prev),
      .new_i      (new_entry),
      .prev_i     (prev_entry),
      .next_i     (next_entry),
      .entry_o    (cell_entry[i]),
      .ge_o       (cell_ge[i])
    );
  end

  // output register: advance the head of the row into it on every pop
  always_comb begin
    out_vld_d = out_vld_q;
    if (pop) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q      <= cell_entry[0];
      out_last_q <= (count_q == CntBits'(1));
      out_drop_q <= ovf_q;
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.out_tag  = out_q.tag;
  assign out_o.out_x    = out_q.x;
  assign out_o.out_y    = out_q.y;
  assign out_o.out_last = out_last_q;
  assign out_o.dropped  = out_drop_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntBits'(MaxSprites))
    else $error("held count beyond capacity");

  a_no_insert_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dstat.valid |-> state_q == StFill)
    else $error("sprite reached the row while it drains");

  a_no_accept_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> state_q == StFill && !dstat.final_pending)
    else $error("sprite accepted while a frame closes");

  a_last_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && count_q == CntBits'(1)) |=> (count_q == '0 && state_q == StFill && !ovf_q))
    else $error("row not empty after the last sprite left");

endmodule

// ===== design/sds_dist.sv =====
module sds_dist import sds_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_fire_i,
  input  logic [CoordBits-1:0] player_x_i,
  input  logic [CoordBits-1:0] player_y_i,
  input  logic [CoordBits-1:0] sprite_x_i,
  input  logic [CoordBits-1:0] sprite_y_i,
  input  logic [TagBits-1:0]   sprite_tag_i,
  input  logic                 final_sprite_i,
  output dist_stat_t           stat_o,
  output entry_t               entry_o
);

  logic                 a_vld_q, a_fin_q;
  logic [CoordBits-1:0] a_dx_q, a_dy_q, a_x_q, a_y_q;
  logic [TagBits-1:0]   a_tag_q;
  logic [CoordBits-1:0] a_dx_d, a_dy_d;

  logic                 b_vld_q, b_fin_q;
  logic [SqBits-1:0]    b_sqx_q, b_sqy_q;
  logic [SqBits-1:0]    b_sqx_d, b_sqy_d;
  logic [CoordBits-1:0] b_x_q, b_y_q;
  logic [TagBits-1:0]   b_tag_q;

  // absolute coordinate differences
  always_comb begin
    a_dx_d = (player_x_i >= sprite_x_i) ? player_x_i - sprite_x_i : sprite_x_i - player_x_i;
    a_dy_d = (player_y_i >= sprite_y_i) ? player_y_i - sprite_y_i : sprite_y_i - player_y_i;
  end

  assign b_sqx_d = SqBits'(a_dx_q) * SqBits'(a_dx_q);
  assign b_sqy_d = SqBits'(a_dy_q) * SqBits'(a_dy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      a_fin_q <= 1'b0;
      b_vld_q <= 1'b0;
      b_fin_q <= 1'b0;
    end else begin
      a_vld_q <= in_fire_i;
      a_fin_q <= in_fire_i & final_sprite_i;
      b_vld_q <= a_vld_q;
      b_fin_q <= a_fin_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      a_dx_q  <= a_dx_d;
      a_dy_q  <= a_dy_d;
      a_x_q   <= sprite_x_i;
      a_y_q   <= sprite_y_i;
      a_tag_q <= sprite_tag_i;
    end
    if (a_vld_q) begin
      b_sqx_q <= b_sqx_d;
      b_sqy_q <= b_sqy_d;
      b_x_q   <= a_x_q;
      b_y_q   <= a_y_q;
      b_tag_q <= a_tag_q;
    end
  end

  assign entry_o.dist_sq = DistBits'(b_sqx_q) + DistBits'(b_sqy_q);
  assign entry_o.x       = b_x_q;
  assign entry_o.y       = b_y_q;
  assign entry_o.tag     = b_tag_q;

  assign stat_o.valid         = b_vld_q;
  assign stat_o.final_sprite  = b_fin_q;
  assign stat_o.final_pending = a_fin_q | b_fin_q;

endmodule

// ===== design/sds_cell.sv =====
module sds_cell import sds_pkg::*; (
  input  logic     clk_i,
  input  cell_op_e op_i,
  input  logic     occupied_i,
  input  logic     ge_prev_i,
  input  entry_t   new_i,
  input  entry_t   prev_i,
  input  entry_t   next_i,
  output entry_t   entry_o,
  output logic     ge_o
);

  entry_t entry_q, entry_d;

  // this entry stays ahead of the new one: at least as far (ties keep arrival order)
  assign ge_o = occupied_i & (entry_q.dist_sq >= new_i.dist_sq);

  always_comb begin
    entry_d = entry_q;
    case (op_i)
      OpInsert: begin
        if (!ge_o) begin
          entry_d = ge_prev_i ? new_i : prev_i;
        end
      end
      OpShift: begin
        entry_d = next_i;
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
